// ----- rtl/core/ssoc_pkg.sv -----
// Shared types and constants for the sorted set overlap counter.
package ssoc_pkg;

  localparam int DEF_LIST_CAPACITY = 1024;
  localparam int DEF_KEY_BITS      = 32;

  localparam int KEY_W      = 32;  // key field on the input channel
  localparam int COUNT_BITS = 11;
  localparam int FRAG_BITS  = 16;
  localparam int THIRD_BITS = 15;  // floor(65535 / 3) = 21845 fits

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // floor(x / 3) == (x * 43691) >> 17 for any 16-bit x
  localparam int              THIRD_SHIFT = 17;
  localparam int              THIRD_PROD_W = FRAG_BITS + THIRD_SHIFT;
  localparam logic [THIRD_PROD_W-1:0] THIRD_MUL = THIRD_PROD_W'(43691);

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_BKEY   = 2'd1,
    MODE_END    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // controller -> datapath
  typedef struct packed {
    logic append;
    logic load_key;
    logic step;
    logic hit;
    logic emit;
    logic clear;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cur_valid;
    logic a_less;
    logic a_equal;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/ssoc_if.sv -----
// Valid/ready channel interfaces for input, result and configuration beats.
interface ssoc_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [ssoc_pkg::KEY_W-1:0]   key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

interface ssoc_out_if;
  logic                              valid;
  logic                              ready;
  logic [ssoc_pkg::COUNT_BITS-1:0]   shared_count;
  logic                              linked;
  logic                              overflow;

  modport source (output valid, output shared_count, output linked, output overflow,
                  input ready);
  modport sink   (input valid, input shared_count, input linked, input overflow,
                  output ready);
endinterface

interface ssoc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ssoc_pkg::FRAG_BITS-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/ssoc_ctrl.sv -----
// Sequencing state machine: decodes beats and drives the merge walk.
module ssoc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  output logic              in_ready,
  output ssoc_pkg::dp_cmd_t cmd,
  input  ssoc_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  ssoc_pkg::mode_t mode;

  assign mode     = ssoc_pkg::mode_t'(in_mode);
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            ssoc_pkg::MODE_APPEND: cmd.append = 1'b1;
            ssoc_pkg::MODE_BKEY: begin
              cmd.load_key = 1'b1;
              if (sts.cur_valid) state_nxt = ST_CMP;
            end
            ssoc_pkg::MODE_END: begin
              if (sts.out_free) cmd.emit = 1'b1;
              else state_nxt = ST_HOLD;
            end
            ssoc_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        // rd data is A[cursor]; keep skipping while A key < B key
        if (!sts.cur_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.a_less) begin
          cmd.step = 1'b1;
        end else begin
          cmd.hit   = sts.a_equal;
          state_nxt = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/ssoc_dp.sv -----
// Datapath: list A memory, cursor, length, match count and result register.
module ssoc_dp #(
  parameter int LIST_CAPACITY = ssoc_pkg::DEF_LIST_CAPACITY,
  parameter int KEY_BITS      = ssoc_pkg::DEF_KEY_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ssoc_pkg::dp_cmd_t                 cmd,
  output ssoc_pkg::dp_sts_t                 sts,
  input  logic [ssoc_pkg::KEY_W-1:0]        in_key,
  input  logic                              cfg_valid,
  input  logic [ssoc_pkg::FRAG_BITS-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ssoc_pkg::COUNT_BITS-1:0]   out_shared_count,
  output logic                              out_linked,
  output logic                              out_overflow
);

  localparam int STORE_BITS = (KEY_BITS < ssoc_pkg::KEY_W) ? KEY_BITS : ssoc_pkg::KEY_W;
  localparam int ADDR_BITS  = $clog2(LIST_CAPACITY);
  localparam int LEN_BITS   = $clog2(LIST_CAPACITY + 1);
  localparam logic [LEN_BITS-1:0] CAP = LEN_BITS'(LIST_CAPACITY);

  logic [STORE_BITS-1:0] mem [LIST_CAPACITY];

  logic [STORE_BITS-1:0]              key_r, rd_data_r, key_in;
  logic [LEN_BITS-1:0]                len_r, cursor_r, cursor_nxt;
  logic [ssoc_pkg::COUNT_BITS-1:0]    count_r;
  logic                               ovf_r;
  logic [ssoc_pkg::THIRD_BITS-1:0]    third_r;
  logic [ssoc_pkg::THIRD_PROD_W-1:0]  third_prod;
  logic                               out_valid_r;
  logic [ssoc_pkg::COUNT_BITS-1:0]    out_count_r;
  logic                               out_linked_r, out_ovf_r;
  logic                               len_full;

  assign key_in   = in_key[STORE_BITS-1:0];
  assign len_full = (len_r == CAP);

  assign third_prod = ssoc_pkg::THIRD_PROD_W'(cfg_data) * ssoc_pkg::THIRD_MUL;

  always_comb begin
    cursor_nxt = cursor_r;
    if (cmd.clear || cmd.emit) cursor_nxt = '0;
    else if (cmd.step || cmd.hit) cursor_nxt = cursor_r + LEN_BITS'(1);
  end

  assign sts.cur_valid = (cursor_r < len_r);
  assign sts.a_less    = (rd_data_r < key_r);
  assign sts.a_equal   = (rd_data_r == key_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      cursor_r    <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      third_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      if (cfg_valid) third_r <= third_prod[ssoc_pkg::THIRD_SHIFT +: ssoc_pkg::THIRD_BITS];

      if (cmd.clear) begin
        len_r   <= '0;
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (cmd.append) begin
        if (len_full) ovf_r <= 1'b1;
        else len_r <= len_r + LEN_BITS'(1);
      end else if (cmd.emit) begin
        count_r <= '0;
      end else if (cmd.hit && count_r != ssoc_pkg::COUNT_MAX) begin
        count_r <= count_r + ssoc_pkg::COUNT_BITS'(1);
      end

      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload: memory port, key latch, result fields
  always_ff @(posedge clk) begin
    if (cmd.append && !len_full) mem[len_r[ADDR_BITS-1:0]] <= key_in;
    rd_data_r <= mem[cursor_nxt[ADDR_BITS-1:0]];
    if (cmd.load_key) key_r <= key_in;
    if (cmd.emit) begin
      out_count_r  <= count_r;
      out_linked_r <= (ssoc_pkg::THIRD_BITS'(count_r) > third_r);
      out_ovf_r    <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_shared_count = out_count_r;
  assign out_linked       = out_linked_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ----- rtl/core/sorted_set_overlap_counter_core.sv -----
// Top level of the sorted set overlap counter: controller plus datapath.
//
// Counts keys shared by a stored ascending list A and a streamed ascending
// list B. Mode 3 clears A, the count and the overflow flag; mode 0 appends a
// key to A (dropped with a sticky overflow flag once LIST_CAPACITY keys are
// held); mode 1 presents a B key and merges it against A; mode 2 emits one
// result beat (shared_count, linked = count > floor(fragment length / 3),
// overflow) and rewinds the cursor and count while keeping A. Mode 2 waits
// in a hold state while the result register is full, until the previous
// result beat is taken. A mode 1 beat holds off further input while it
// skips the A keys below the B key; each merge step is one read of the
// list A memory through its registered read port, which sets the pace.
// The result register holds a finished beat while new input beats are
// taken. The fragment length is written over the cfg channel (always
// ready) and takes effect on the next cycle. List A needs no clearing
// pass after reset: only entries below its length are ever read.
module sorted_set_overlap_counter_core #(
  parameter int LIST_CAPACITY = ssoc_pkg::DEF_LIST_CAPACITY,
  parameter int KEY_BITS      = ssoc_pkg::DEF_KEY_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  ssoc_in_if.sink     in_bus,
  ssoc_out_if.source  out_bus,
  ssoc_cfg_if.sink    cfg_bus
);

  ssoc_pkg::dp_cmd_t cmd;
  ssoc_pkg::dp_sts_t sts;

  // configuration register never stalls
  assign cfg_bus.ready = 1'b1;

  ssoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_mode  (in_bus.mode),
    .in_ready (in_bus.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ssoc_dp #(
    .LIST_CAPACITY (LIST_CAPACITY),
    .KEY_BITS      (KEY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_key           (in_bus.key),
    .cfg_valid        (cfg_bus.valid),
    .cfg_data         (cfg_bus.data),
    .out_valid        (out_bus.valid),
    .out_ready        (out_bus.ready),
    .out_shared_count (out_bus.shared_count),
    .out_linked       (out_bus.linked),
    .out_overflow     (out_bus.overflow)
  );

endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for the sorted set overlap counter core.
`timescale 1ns / 1ps

// Expected result of one end-of-pair beat.
typedef struct packed {
  logic [ssoc_pkg::COUNT_BITS-1:0] shared_count;
  logic                            linked;
  logic                            overflow;
} overlap_report_t;

// Tracks list A, the merge cursor and the running count; queues the reports
// that end-of-pair beats must produce.
class overlap_tracker;
  localparam int LIST_CAP = ssoc_pkg::DEF_LIST_CAPACITY;

  logic [31:0]     list_a [LIST_CAP];
  int unsigned     a_len;
  int unsigned     a_cursor;
  int unsigned     hits;
  bit              dropped;
  logic [15:0]     nominal_len;
  overlap_report_t pending_reports[$];
  int unsigned     errors;

  function new();
    a_len       = 0;
    a_cursor    = 0;
    hits        = 0;
    dropped     = 1'b0;
    nominal_len = '0;
    errors      = 0;
  endfunction

  function void set_nominal_len(logic [15:0] value);
    nominal_len = value;
  endfunction

  function int waiting();
    return pending_reports.size();
  endfunction

  // Advance the model by one accepted input beat.
  function void take_input_beat(ssoc_pkg::mode_t m, logic [31:0] k);
    overlap_report_t rpt;
    case (m)
      ssoc_pkg::MODE_APPEND: begin
        if (a_len < LIST_CAP) begin
          list_a[a_len] = k;
          a_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      ssoc_pkg::MODE_BKEY: begin
        while (a_cursor < a_len && list_a[a_cursor] < k) a_cursor++;
        if (a_cursor < a_len && list_a[a_cursor] == k) begin
          a_cursor++;
          if (hits < 2047) hits++;
        end
      end
      ssoc_pkg::MODE_END: begin
        rpt.shared_count = hits[ssoc_pkg::COUNT_BITS-1:0];
        rpt.linked       = (hits > (nominal_len / 16'd3));
        rpt.overflow     = dropped;
        pending_reports.insert(pending_reports.size(), rpt);
        hits     = 0;
        a_cursor = 0;
      end
      default: begin
        a_len    = 0;
        a_cursor = 0;
        hits     = 0;
        dropped  = 1'b0;
      end
    endcase
  endfunction

  // Compare one result beat against the oldest expected report.
  function void match_report(logic [ssoc_pkg::COUNT_BITS-1:0] cnt, logic lnk, logic ovf);
    overlap_report_t exp_rpt;
    if (pending_reports.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result beat: shared_count %0d linked %0d overflow %0d",
                 cnt, lnk, ovf);
      return;
    end
    exp_rpt = pending_reports.pop_front();
    if (cnt !== exp_rpt.shared_count || lnk !== exp_rpt.linked ||
        ovf !== exp_rpt.overflow) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: shared_count exp %0d got %0d, linked exp %0d got %0d, %s %0d got %0d",
                 exp_rpt.shared_count, cnt, exp_rpt.linked, lnk,
                 "overflow exp", exp_rpt.overflow, ovf);
    end
  endfunction
endclass

module testbench;
  import ssoc_pkg::*;

  localparam int LIST_CAP     = DEF_LIST_CAPACITY;
  // Drain time covers the longest B-key beat, a full scan of list A.
  localparam int DRAIN_CYCLES = LIST_CAP + 16;
  localparam int PHASE_BEATS  = 75;
  localparam int HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n;

  ssoc_in_if  in_bus();
  ssoc_out_if out_bus();
  ssoc_cfg_if cfg_bus();

  overlap_tracker tracker = new();

  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_left     = 0;
  int unsigned beats_sent    = 0;
  logic [31:0] cur_a[$];

  logic [15:0] frag_plan [9] = '{16'd3, 16'd0, 16'd65535, 16'd7, 16'd20,
                                 16'd1, 16'd2, 16'd40000, 16'd12};

  sorted_set_overlap_counter_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      tracker.match_report(out_bus.shared_count, out_bus.linked, out_bus.overflow);
  end

  // Entered at a falling edge; returns at the falling edge after the beat.
  task automatic send_beat(input mode_t m, input logic [31:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode  <= m;
    in_bus.key   <= k;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    tracker.take_input_beat(m, k);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_nominal_len(input logic [15:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    tracker.set_nominal_len(value);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait for every report, then give a pending B-key scan time to finish.
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void sort_keys(ref logic [31:0] q[$]);
    logic [31:0] t;
    int          j;
    for (int i = 1; i < q.size(); i++) begin
      t = q[i];
      j = i - 1;
      while (j >= 0 && q[j] > t) begin
        q[j+1] = q[j];
        j--;
      end
      q[j+1] = t;
    end
  endfunction

  // One A list (fresh or kept) then 1-4 B lists with end beats, or random noise.
  task automatic run_pair_set();
    logic [31:0] a_keys[$];
    logic [31:0] b_keys[$];
    logic [31:0] t;
    int          n_a;
    int          pos;
    // noise: random modes and keys
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8, 20)) send_beat(mode_t'($urandom_range(3)), $urandom);
      send_beat(MODE_END, $urandom);
      return;
    end
    // mostly a fresh A; otherwise A is kept from before
    if ($urandom_range(4) != 0) begin
      send_beat(MODE_CLEAR, $urandom);
      n_a = ($urandom_range(15) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 16);
      repeat (n_a) a_keys.insert(a_keys.size(), $urandom);
      sort_keys(a_keys);
      foreach (a_keys[i]) send_beat(MODE_APPEND, a_keys[i]);
      cur_a = a_keys;
    end
    repeat ($urandom_range(1, 4)) begin
      b_keys.delete();
      foreach (cur_a[i]) if ($urandom_range(9) < 6) b_keys.insert(b_keys.size(), cur_a[i]);
      repeat ($urandom_range(0, 6)) b_keys.insert(b_keys.size(), $urandom);
      sort_keys(b_keys);
      // occasionally break the ordering
      if (b_keys.size() > 1 && $urandom_range(9) == 0) begin
        pos           = $urandom_range(0, b_keys.size() - 2);
        t             = b_keys[pos];
        b_keys[pos]   = b_keys[pos+1];
        b_keys[pos+1] = t;
      end
      foreach (b_keys[i]) send_beat(MODE_BKEY, b_keys[i]);
      send_beat(MODE_END, $urandom);
    end
  endtask

  // Fill A to capacity, push past it, and run long merge scans.
  task automatic run_full_list_set();
    logic [31:0] k;
    send_beat(MODE_CLEAR, $urandom);
    cur_a.delete();
    for (int i = 0; i < LIST_CAP; i++) begin
      k = (32'(i) << 22) | 32'($urandom_range(0, (1 << 22) - 1));
      cur_a.insert(cur_a.size(), k);
      send_beat(MODE_APPEND, k);
    end
    repeat (3) send_beat(MODE_APPEND, $urandom);  // dropped, sets overflow
    foreach (cur_a[i]) if (i % 8 == 3) send_beat(MODE_BKEY, cur_a[i]);
    send_beat(MODE_BKEY, 32'hFFFF_FFFF);
    send_beat(MODE_END, $urandom);
    // one key that skips almost the whole list
    send_beat(MODE_BKEY, cur_a[LIST_CAP-1]);
    send_beat(MODE_END, $urandom);
  endtask

  initial begin
    int unsigned phase_start;
    in_bus.valid  = 1'b0;
    in_bus.mode   = MODE_APPEND;
    in_bus.key    = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: threshold 1, so a count of 3 links and 1 does not
    write_nominal_len(frag_plan[0]);
    send_beat(MODE_BKEY,   32'hFFFF_FFFF);  // empty A, ignored
    send_beat(MODE_END,    32'h0000_0000);  // count 0
    send_beat(MODE_APPEND, 32'h0000_0000);
    send_beat(MODE_APPEND, 32'h0000_0005);
    send_beat(MODE_APPEND, 32'h7FFF_FFFF);
    send_beat(MODE_APPEND, 32'hFFFF_FFFF);
    send_beat(MODE_BKEY,   32'h0000_0000);  // hit
    send_beat(MODE_BKEY,   32'h0000_0003);  // miss
    send_beat(MODE_BKEY,   32'h0000_0005);  // hit
    send_beat(MODE_BKEY,   32'hFFFF_FFFF);  // skip one, hit
    send_beat(MODE_BKEY,   32'hFFFF_FFFF);  // A used up
    send_beat(MODE_END,    32'hFFFF_FFFF);  // count 3
    send_beat(MODE_BKEY,   32'h0000_0005);
    send_beat(MODE_BKEY,   32'h0000_0000);  // out of order, missed
    send_beat(MODE_END,    32'h0000_0000);  // count 1
    send_beat(MODE_BKEY,   32'h7FFF_FFFF);  // A kept across pairs
    send_beat(MODE_END,    32'h0000_0000);
    send_beat(MODE_CLEAR,  32'hFFFF_FFFF);
    send_beat(MODE_APPEND, 32'h0000_000A);
    send_beat(MODE_APPEND, 32'h0000_0003);  // unsorted A
    send_beat(MODE_BKEY,   32'h0000_0003);
    send_beat(MODE_BKEY,   32'h0000_000A);
    send_beat(MODE_END,    32'h0000_0000);
    send_beat(MODE_CLEAR,  32'h0000_0000);
    send_beat(MODE_END,    32'hFFFF_FFFF);  // count 0 after clear

    // random phases, cycling through the idle patterns
    for (int p = 1; p <= 8; p++) begin
      settle();
      write_nominal_len(p == 4 ? 16'($urandom_range(0, 40)) :
                        p == 7 ? 16'($urandom) : frag_plan[p]);
      case ((p - 1) % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 77; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      // result side blocked while input keeps coming
      if (p == 5) hold_left = HOLD_CYCLES;
      phase_start = beats_sent;
      if (p == 2) run_full_list_set();
      while (beats_sent - phase_start < PHASE_BEATS) run_pair_set();
    end

    settle();
    write_nominal_len(frag_plan[8]);
    send_beat(MODE_BKEY, 32'h0000_0000);
    send_beat(MODE_END, 32'h0000_0000);
    settle();

    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
